>>> src/ppte_pkg.sv
package ppte_pkg;

  // Command codes
  localparam logic [1:0] FUNC_LOAD_COEFF = 2'd0;
  localparam logic [1:0] FUNC_LOAD_DUR   = 2'd1;
  localparam logic [1:0] FUNC_EVAL       = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_HOVER_X = 2'd0;
  localparam logic [1:0] REG_HOVER_Y = 2'd1;
  localparam logic [1:0] REG_HOVER_Z = 2'd2;

  // Derivative order of one Horner pass
  localparam logic [1:0] KIND_POS = 2'd0;
  localparam logic [1:0] KIND_VEL = 2'd1;
  localparam logic [1:0] KIND_ACC = 2'd2;

  localparam logic signed [63:0] HOVER_Z_RESET = 64'sh0000_0002_0000_0000;
  localparam logic signed [63:0] S64_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic [1:0]         func;
    logic [3:0]         row_index;
    logic [4:0]         coeff_index;
    logic signed [63:0] load_value;
    logic [31:0]        eval_time;
  } cmd_t;

  typedef struct packed {
    logic signed [63:0] pos_x;
    logic signed [63:0] pos_y;
    logic signed [63:0] pos_z;
    logic signed [63:0] vel_x;
    logic signed [63:0] vel_y;
    logic signed [63:0] vel_z;
    logic signed [63:0] acc_x;
    logic signed [63:0] acc_y;
    logic signed [63:0] acc_z;
    logic [3:0]         segment_found;
    logic               past_end;
  } res_t;

  // Derivative factor of power p: 1, p or p*(p-1)
  function automatic logic [7:0] deriv_fact(input logic [3:0] p, input logic [1:0] kind);
    logic [7:0] pw;
    pw = {4'b0, p};
    case (kind)
      KIND_POS: deriv_fact = 8'd1;
      KIND_VEL: deriv_fact = pw;
      default:  deriv_fact = pw * (pw - 8'd1);
    endcase
  endfunction

endpackage

>>> src/ppte_ram.sv
module ppte_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/piecewise_poly_trajectory_eval_core.sv
// Channel   Ports                          Handshake
// command   start, busy, cmd               beat taken when start & !busy
// config    cfg_we, cfg_index, cfg_data    written when cfg_we is high
// result    done, result                   beat shown for one cycle on done
//
// Loads write the tables directly and leave busy low. An evaluation walks the
// duration table row by row, then runs Horner passes on one shared 33x33
// multiplier: the leading term is read and scaled; every other term is read,
// multiplied, rounded and added. Synchronous reset clears control, zeroes
// hover X and Y and sets hover Z to HOVER_Z_RESET; the tables stay undefined
// until loaded. The receiver cannot stall: done lasts one cycle.
module piecewise_poly_trajectory_eval_core
  import ppte_pkg::*;
#(
  parameter int TABLE_ROWS      = 16,
  parameter int COEFFS_PER_AXIS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  cmd_t        cmd,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic        done,
  output res_t        result
);

  localparam int ROW_WORDS = 3 * COEFFS_PER_AXIS;
  localparam int RW        = $clog2(TABLE_ROWS);
  localparam int CDEPTH    = TABLE_ROWS * ROW_WORDS;
  localparam int CAW       = $clog2(CDEPTH);
  localparam int PW        = $clog2(COEFFS_PER_AXIS);
  localparam int SW        = 32 + RW + 1;
  localparam logic [1:0] LAST_KIND = (COEFFS_PER_AXIS > 2) ? KIND_ACC : KIND_VEL;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRD  = 3'd1;
  localparam logic [2:0] S_SACC = 3'd2;
  localparam logic [2:0] S_CRD  = 3'd3;
  localparam logic [2:0] S_CSCL = 3'd4;
  localparam logic [2:0] S_MR   = 3'd5;
  localparam logic [2:0] S_ADD  = 3'd6;

  logic [2:0]         state;
  logic signed [63:0] hover [3];
  logic signed [63:0] res [3][3];
  logic [3:0]         seg_out;
  logic               past_out;

  logic [RW-1:0]      idx;
  logic [SW-1:0]      run;
  logic [SW-1:0]      seg_start;
  logic [RW-1:0]      seg;
  logic [31:0]        t_reg;
  logic [31:0]        tau;
  logic [CAW-1:0]     base;
  logic [1:0]         axis;
  logic [1:0]         kind;
  logic [PW-1:0]      pwr;
  logic               first;
  logic signed [63:0] acc;
  logic signed [63:0] cterm;
  logic signed [63:0] mt;
  logic [63:0]        pp_lo;
  logic signed [64:0] pp_hi;

  logic               accept;
  logic [RW+3:0]      row_w;
  logic               c_we;
  logic [CAW-1:0]     c_waddr;
  logic [CAW-1:0]     c_raddr;
  logic [63:0]        c_rdata;
  logic               d_we;
  logic [RW-1:0]      d_waddr;
  logic [31:0]        d_rdata;
  logic [SW-1:0]      run_n;
  logic [SW-1:0]      t_ext;
  logic [RW+3:0]      seg_w;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;
  logic signed [72:0] sc_prod;
  logic signed [63:0] scaled;
  logic signed [97:0] rnd_full;
  logic signed [63:0] rnd_sat;
  logic signed [64:0] sum65;
  logic signed [63:0] add_sat;
  logic               step_done;
  logic signed [63:0] step_val;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign row_w  = {{RW{1'b0}}, cmd.row_index};

  // Load ports of both tables
  assign c_we    = accept && (cmd.func == FUNC_LOAD_COEFF) && (row_w < TABLE_ROWS)
                   && ({27'b0, cmd.coeff_index} < ROW_WORDS);
  assign c_waddr = CAW'(row_w * ROW_WORDS + cmd.coeff_index);
  assign d_we    = accept && (cmd.func == FUNC_LOAD_DUR) && (row_w < TABLE_ROWS);
  assign d_waddr = row_w[RW-1:0];
  assign c_raddr = CAW'(base + axis * COEFFS_PER_AXIS + pwr);

  ppte_ram #(.WIDTH(64), .DEPTH(CDEPTH)) u_coeff (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(cmd.load_value),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  ppte_ram #(.WIDTH(32), .DEPTH(TABLE_ROWS)) u_dur (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(cmd.load_value[31:0]),
    .raddr(idx), .rdata(d_rdata)
  );

  assign run_n = run + {{(SW-32){1'b0}}, d_rdata};
  assign t_ext = {{(SW-32){1'b0}}, t_reg};
  assign seg_w = {4'b0, seg};

  // Shared multiplier: low half of acc in S_CRD, high half in S_CSCL
  assign mul_a = (state == S_CRD) ? $signed({1'b0, acc[31:0]}) : $signed({acc[63], acc[63:32]});
  assign mul_b = $signed({1'b0, tau});
  assign mul_p = mul_a * mul_b;

  // Scale coefficient by its derivative factor, saturate
  always_comb begin
    sc_prod = $signed(c_rdata) * $signed({1'b0, deriv_fact(4'(pwr), kind)});
    if ((&sc_prod[72:63]) || !(|sc_prod[72:63])) begin
      scaled = sc_prod[63:0];
    end else begin
      scaled = sc_prod[72] ? S64_MIN : S64_MAX;
    end
  end

  // Round Q48.48 product to Q32.32, ties up, saturate
  always_comb begin
    rnd_full = ($signed({{33{pp_hi[64]}}, pp_hi}) <<< 32) + $signed({34'b0, pp_lo})
               + 98'sh8000;
    if ((&rnd_full[97:79]) || !(|rnd_full[97:79])) begin
      rnd_sat = rnd_full[79:16];
    end else begin
      rnd_sat = rnd_full[97] ? S64_MIN : S64_MAX;
    end
  end

  // Saturating add of the next term
  always_comb begin
    sum65 = {mt[63], mt} + {cterm[63], cterm};
    if (sum65[64] == sum65[63]) begin
      add_sat = sum65[63:0];
    end else begin
      add_sat = sum65[64] ? S64_MIN : S64_MAX;
    end
  end

  assign step_done = ((state == S_CSCL) && first) || (state == S_ADD);
  assign step_val  = (state == S_ADD) ? add_sat : scaled;

  // Hover registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hover[0] <= '0;
      hover[1] <= '0;
      hover[2] <= HOVER_Z_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HOVER_X: hover[0] <= cfg_data;
        REG_HOVER_Y: hover[1] <= cfg_data;
        REG_HOVER_Z: hover[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: segment search, then, unless past the end, Horner passes per axis and order
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && (cmd.func == FUNC_EVAL)) begin
            t_reg     <= cmd.eval_time;
            idx       <= RW'(1);
            run       <= '0;
            seg       <= '0;
            seg_start <= '0;
            state     <= S_SRD;
          end
        end
        S_SRD: state <= S_SACC;
        S_SACC: begin
          run <= run_n;
          if ((idx != RW'(TABLE_ROWS - 1)) && (run_n <= t_ext)) begin
            seg       <= idx;
            seg_start <= run_n;
          end
          if (idx == RW'(TABLE_ROWS - 1)) begin
            for (int k = 0; k < 3; k++) begin
              for (int a = 0; a < 3; a++) begin
                res[k][a] <= (k == 0 && t_ext >= run_n) ? hover[a] : '0;
              end
            end
            if (t_ext >= run_n) begin
              seg_out  <= '0;
              past_out <= 1'b1;
              done     <= 1'b1;
              state    <= S_IDLE;
            end else begin
              seg_out  <= seg_w[3:0];
              past_out <= 1'b0;
              tau      <= 32'(t_ext - seg_start);
              base     <= CAW'(seg * ROW_WORDS);
              axis     <= 2'd0;
              kind     <= KIND_POS;
              pwr      <= PW'(COEFFS_PER_AXIS - 1);
              first    <= 1'b1;
              state    <= S_CRD;
            end
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SRD;
          end
        end
        S_CRD: begin
          pp_lo <= mul_p[63:0];
          state <= S_CSCL;
        end
        S_CSCL: begin
          pp_hi <= mul_p[64:0];
          cterm <= scaled;
          if (!first) begin
            state <= S_MR;
          end
        end
        S_MR: begin
          mt    <= rnd_sat;
          state <= S_ADD;
        end
        S_ADD: ;
        default: state <= S_IDLE;
      endcase

      // Finish one Horner step: hold acc, step power, or close the pass
      if (step_done) begin
        acc <= step_val;
        if ({{(4-PW){1'b0}}, pwr} == {2'b0, kind}) begin
          res[kind][axis] <= step_val;
          first <= 1'b1;
          pwr   <= PW'(COEFFS_PER_AXIS - 1);
          state <= S_CRD;
          if (kind == LAST_KIND) begin
            kind <= KIND_POS;
            axis <= axis + 2'd1;
            if (axis == 2'd2) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end else begin
            kind <= kind + 2'd1;
          end
        end else begin
          first <= 1'b0;
          pwr   <= pwr - 1'b1;
          state <= S_CRD;
        end
      end
    end
  end

  // Result beat
  always_comb begin
    result.pos_x         = res[0][0];
    result.pos_y         = res[0][1];
    result.pos_z         = res[0][2];
    result.vel_x         = res[1][0];
    result.vel_y         = res[1][1];
    result.vel_z         = res[1][2];
    result.acc_x         = res[2][0];
    result.acc_y         = res[2][1];
    result.acc_z         = res[2][2];
    result.segment_found = seg_out;
    result.past_end      = past_out;
  end

endmodule
